/* hdl/mfa_pkg.sv */
// Shared types and constants of the mixed fraction ALU.
package mfa_pkg;

	localparam int WORD_BITS  = 64;
	localparam int CNT_BITS   = 7;
	localparam int WHOLE_BITS = 63;
	localparam int DEN_BITS   = 62;

	localparam logic [2:0] FN_ADD = 3'd0;
	localparam logic [2:0] FN_SUB = 3'd1;
	localparam logic [2:0] FN_MUL = 3'd2;
	localparam logic [2:0] FN_DIV = 3'd3;
	localparam logic [2:0] FN_CMP = 3'd4;

	localparam logic [1:0] ORD_LT = 2'd0;
	localparam logic [1:0] ORD_EQ = 2'd1;
	localparam logic [1:0] ORD_GT = 2'd2;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LA,
		ST_LB,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_PREP,
		ST_GCD,
		ST_RA,
		ST_RD,
		ST_QR,
		ST_OUT
	} state_t;

endpackage

/* hdl/mfa_req_if.sv */
// Request channel: operation code and two mixed fraction operands.
interface mfa_req_if #(parameter int OPERAND_BITS = 16);
	logic                           valid;
	logic                           ready;
	logic [2:0]                     func;
	logic signed [OPERAND_BITS-1:0] a_whole;
	logic signed [OPERAND_BITS-1:0] a_num;
	logic signed [OPERAND_BITS-1:0] a_den;
	logic signed [OPERAND_BITS-1:0] b_whole;
	logic signed [OPERAND_BITS-1:0] b_num;
	logic signed [OPERAND_BITS-1:0] b_den;

	modport source (output valid, func, a_whole, a_num, a_den, b_whole, b_num, b_den,
		input ready);
	modport sink (input valid, func, a_whole, a_num, a_den, b_whole, b_num, b_den,
		output ready);
endinterface

/* hdl/mfa_rsp_if.sv */
// Response channel: reduced mixed fraction, compare order and error flag.
interface mfa_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [62:0] res_whole;
	logic signed [62:0] res_num;
	logic [61:0]        res_den;
	logic [1:0]         order;
	logic               div_error;

	modport source (output valid, res_whole, res_num, res_den, order, div_error,
		input ready);
	modport sink (input valid, res_whole, res_num, res_den, order, div_error,
		output ready);
endinterface

/* hdl/mfa_mul.sv */
// Shift-add multiplier giving the low 64 bits of a 64 by 64 product.
module mfa_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  mfa_pkg::word_t a,
	input  mfa_pkg::word_t b,
	output logic          busy,
	output logic          done,
	output mfa_pkg::word_t p
);
	import mfa_pkg::*;

	word_t a_q, b_q, acc_q;
	logic  busy_q;

	// Run until the multiplier runs out of set bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && b_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	// Add the shifted multiplicand for each set bit
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[WORD_BITS-2:0], 1'b0};
			b_q <= {1'b0, b_q[WORD_BITS-1:1]};
		end
	end

	assign busy = busy_q;
	assign done = busy_q && b_q == '0;
	assign p    = acc_q;
endmodule

/* hdl/mfa_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned 64 by 64.
module mfa_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  mfa_pkg::word_t n,
	input  mfa_pkg::word_t d,
	output logic          busy,
	output logic          done,
	output mfa_pkg::word_t q,
	output mfa_pkg::word_t r
);
	import mfa_pkg::*;

	word_t                 n_q, d_q, rem_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  busy_q;
	logic [WORD_BITS:0]    shifted, diff;
	logic                  last;

	assign shifted = {rem_q, n_q[WORD_BITS-1]};
	assign diff    = shifted - {1'b0, d_q};
	assign last    = cnt_q == CNT_BITS'(WORD_BITS);

	// Count the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Trial subtract and shift in one quotient bit
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n;
			d_q   <= d;
			rem_q <= '0;
		end else if (busy_q && !last) begin
			if (!diff[WORD_BITS]) begin
				rem_q <= diff[WORD_BITS-1:0];
				n_q   <= {n_q[WORD_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WORD_BITS-1:0];
				n_q   <= {n_q[WORD_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = busy_q && last;
	assign q    = n_q;
	assign r    = rem_q;
endmodule

/* hdl/mixed_fraction_alu.sv */
// Mixed fraction ALU: add, subtract, multiply, divide, compare with reduction.
//
// Usage:
//   req (sink) takes func and two mixed fractions (whole, num, den); a zero
//   denominator counts as one. rsp (source) returns the reduced proper
//   result, the compare order and a divide-by-zero flag. One result per
//   request, in order. A transfer happens when valid and ready are high.
//
// Sequencing:
//   One request at a time; req.ready is high only while the block is idle.
//   Products come from a shift-add multiplier that steps through the bits of
//   its second operand up to the highest set bit. Two to five products are
//   formed per request. Reduction runs Euclid's GCD on a restoring divider,
//   one remainder per step, followed by three more divisions. Latency is
//   data dependent.
//
// Reset: arst_n clears the sequencer to idle; no result is pending.
// Stall: a finished result is held on rsp until rsp.ready is seen; no new
//   request is taken until then.
module mixed_fraction_alu #(
	parameter int OPERAND_BITS = 16
) (
	input logic      clk,
	input logic      arst_n,
	mfa_req_if.sink  req,
	mfa_rsp_if.source rsp
);
	import mfa_pkg::*;

	state_t state_q, state_d;
	logic   go_q, go_d;

	logic [2:0] func_q;
	word_t wa_q, wb_q, n1_q, d1_q, n2_q, d2_q, t_q, num_q, den_q;
	word_t an_q, dd_q, ga_q, gb_q;
	logic  neg_q;

	logic signed [WHOLE_BITS-1:0] res_whole_q, res_num_q;
	logic [DEN_BITS-1:0]          res_den_q;
	logic [1:0]                   order_q;
	logic                         div_error_q;

	logic  mul_start, mul_busy, mul_done;
	word_t mul_a, mul_b, mul_p;
	logic  div_start, div_busy, div_done;
	word_t div_n, div_d, div_q, div_r;

	word_t load_sum, diff, num_mag, q_signed, r_signed;
	word_t a_whole_x, a_num_x, a_den_x, b_whole_x, b_num_x, b_den_x;
	logic  req_xfer, rsp_xfer;

	// Sign-extend the operand fields to the working width
	assign a_whole_x = WORD_BITS'(req.a_whole);
	assign a_num_x   = WORD_BITS'(req.a_num);
	assign a_den_x   = WORD_BITS'(req.a_den);
	assign b_whole_x = WORD_BITS'(req.b_whole);
	assign b_num_x   = WORD_BITS'(req.b_num);
	assign b_den_x   = WORD_BITS'(req.b_den);

	assign req_xfer = req.valid && req.ready;
	assign rsp_xfer = rsp.valid && rsp.ready;

	assign load_sum = mul_p + ((state_q == ST_LA) ? n1_q : n2_q);
	assign diff     = t_q - mul_p;
	assign num_mag  = num_q[WORD_BITS-1] ? -num_q : num_q;
	assign q_signed = neg_q ? -div_q : div_q;
	assign r_signed = neg_q ? -div_r : div_r;

	mfa_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.p      (mul_p)
	);

	mfa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (div_d),
		.busy   (div_busy),
		.done   (div_done),
		.q      (div_q),
		.r      (div_r)
	);

	// Select operands of the shared units by step
	always_comb begin
		mul_a = d1_q;
		mul_b = d2_q;
		div_n = an_q;
		div_d = ga_q;
		case (state_q)
			ST_LA: begin
				mul_a = wa_q;
				mul_b = d1_q;
			end
			ST_LB: begin
				mul_a = wb_q;
				mul_b = d2_q;
			end
			ST_M1: begin
				mul_a = n1_q;
				mul_b = (func_q == FN_MUL) ? n2_q : d2_q;
			end
			ST_M2: begin
				if (func_q == FN_MUL) begin
					mul_a = d1_q;
					mul_b = d2_q;
				end else if (func_q == FN_DIV) begin
					mul_a = d1_q;
					mul_b = n2_q;
				end else begin
					mul_a = n2_q;
					mul_b = d1_q;
				end
			end
			ST_GCD: begin
				div_n = ga_q;
				div_d = gb_q;
			end
			ST_RD: begin
				div_n = dd_q;
				div_d = ga_q;
			end
			ST_QR: begin
				div_n = an_q;
				div_d = dd_q;
			end
			default: ;
		endcase
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= go_d;
		end
	end

	// Advance through the steps, issuing one unit operation at a time
	always_comb begin
		state_d   = state_q;
		go_d      = go_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_LA;
				end
			end
			ST_LA, ST_LB, ST_M1, ST_M2, ST_M3: begin
				if (!go_q) begin
					mul_start = 1'b1;
					go_d      = 1'b1;
				end else if (mul_done) begin
					go_d = 1'b0;
					unique case (state_q)
						ST_LA: state_d = ST_LB;
						ST_LB: begin
							if (func_q > FN_CMP ||
								(func_q == FN_DIV && load_sum == '0)) begin
								state_d = ST_OUT;
							end else begin
								state_d = ST_M1;
							end
						end
						ST_M1: state_d = ST_M2;
						ST_M2: begin
							if (func_q == FN_CMP) begin
								state_d = ST_OUT;
							end else if (func_q == FN_ADD || func_q == FN_SUB) begin
								state_d = ST_M3;
							end else begin
								state_d = ST_PREP;
							end
						end
						default: state_d = ST_PREP;
					endcase
				end
			end
			ST_PREP: begin
				state_d = (num_q == '0) ? ST_OUT : ST_GCD;
			end
			ST_GCD: begin
				if (!go_q) begin
					if (gb_q == '0) begin
						state_d = ST_RA;
					end else begin
						div_start = 1'b1;
						go_d      = 1'b1;
					end
				end else if (div_done) begin
					go_d = 1'b0;
				end
			end
			ST_RA, ST_RD, ST_QR: begin
				if (!go_q) begin
					div_start = 1'b1;
					go_d      = 1'b1;
				end else if (div_done) begin
					go_d = 1'b0;
					unique case (state_q)
						ST_RA:   state_d = ST_RD;
						ST_RD:   state_d = ST_QR;
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_OUT: begin
				if (rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Working registers and result
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			func_q      <= req.func;
			wa_q        <= a_whole_x;
			wb_q        <= b_whole_x;
			n1_q        <= a_num_x;
			n2_q        <= b_num_x;
			d1_q        <= (a_den_x == '0) ? WORD_BITS'(1) : a_den_x;
			d2_q        <= (b_den_x == '0) ? WORD_BITS'(1) : b_den_x;
			res_whole_q <= '0;
			res_num_q   <= '0;
			res_den_q   <= DEN_BITS'(1);
			order_q     <= ORD_LT;
			div_error_q <= 1'b0;
		end
		case (state_q)
			ST_LA: begin
				if (go_q && mul_done) begin
					if (d1_q[WORD_BITS-1]) begin
						n1_q <= -load_sum;
						d1_q <= -d1_q;
					end else begin
						n1_q <= load_sum;
					end
				end
			end
			ST_LB: begin
				if (go_q && mul_done) begin
					if (d2_q[WORD_BITS-1]) begin
						n2_q <= -load_sum;
						d2_q <= -d2_q;
					end else begin
						n2_q <= load_sum;
					end
					if (func_q == FN_DIV && load_sum == '0) begin
						div_error_q <= 1'b1;
					end
				end
			end
			ST_M1: begin
				if (go_q && mul_done) begin
					t_q <= mul_p;
				end
			end
			ST_M2: begin
				if (go_q && mul_done) begin
					case (func_q)
						FN_ADD: num_q <= t_q + mul_p;
						FN_MUL: begin
							num_q <= t_q;
							den_q <= mul_p;
						end
						FN_DIV: begin
							num_q <= mul_p[WORD_BITS-1] ? -t_q : t_q;
							den_q <= mul_p[WORD_BITS-1] ? -mul_p : mul_p;
						end
						default: num_q <= diff;
					endcase
					if (func_q == FN_CMP) begin
						if (diff == '0) begin
							order_q <= ORD_EQ;
						end else if (diff[WORD_BITS-1]) begin
							order_q <= ORD_LT;
						end else begin
							order_q <= ORD_GT;
						end
					end
				end
			end
			ST_M3: begin
				if (go_q && mul_done) begin
					den_q <= mul_p;
				end
			end
			ST_PREP: begin
				neg_q <= num_q[WORD_BITS-1];
				an_q  <= num_mag;
				ga_q  <= num_mag;
				dd_q  <= (den_q == '0) ? WORD_BITS'(1) : den_q;
				gb_q  <= (den_q == '0) ? WORD_BITS'(1) : den_q;
			end
			ST_GCD: begin
				if (go_q && div_done) begin
					ga_q <= gb_q;
					gb_q <= div_r;
				end
			end
			ST_RA: begin
				if (go_q && div_done) begin
					an_q <= div_q;
				end
			end
			ST_RD: begin
				if (go_q && div_done) begin
					dd_q <= div_q;
				end
			end
			ST_QR: begin
				if (go_q && div_done) begin
					res_whole_q <= q_signed[WHOLE_BITS-1:0];
					res_num_q   <= r_signed[WHOLE_BITS-1:0];
					res_den_q   <= dd_q[DEN_BITS-1:0];
				end
			end
			default: ;
		endcase
	end

	assign req.ready     = state_q == ST_IDLE;
	assign rsp.valid     = state_q == ST_OUT;
	assign rsp.res_whole = res_whole_q;
	assign rsp.res_num   = res_num_q;
	assign rsp.res_den   = res_den_q;
	assign rsp.order     = order_q;
	assign rsp.div_error = div_error_q;

	// Never take a request while a result is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid))
		else $error("request taken while result pending");

	// The shared units are started only when free
	assert property (@(posedge clk) disable iff (!arst_n)
		(mul_start |-> !mul_busy) and (div_start |-> !div_busy))
		else $error("shared unit restarted while busy");

	// A divide error comes with a zero result
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.div_error) |-> (rsp.res_num == '0 && rsp.res_den == DEN_BITS'(1)
			&& rsp.res_whole == '0))
		else $error("divide error with nonzero result");

	// A transfer on rsp returns the sequencer to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_xfer |=> state_q == ST_IDLE)
		else $error("sequencer not idle after result transfer");
endmodule

/* dv/mfa_tb_pkg.sv */
// Testbench types for the mixed fraction ALU: request and expected result records.
package mfa_tb_pkg;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [15:0] a_whole;
		logic signed [15:0] a_num;
		logic signed [15:0] a_den;
		logic signed [15:0] b_whole;
		logic signed [15:0] b_num;
		logic signed [15:0] b_den;
	} frac_req_t;

	typedef struct packed {
		logic signed [62:0] res_whole;
		logic signed [62:0] res_num;
		logic [61:0]        res_den;
		logic [1:0]         order;
		logic               div_error;
	} frac_rsp_t;

endpackage

/* dv/mixed_fraction_alu_tb.sv */
// Testbench for the mixed fraction ALU: random and directed fraction operations.
module mixed_fraction_alu_tb;
	import mfa_pkg::*;
	import mfa_tb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;

	mfa_req_if #(.OPERAND_BITS(16)) req ();
	mfa_rsp_if rsp ();

	mixed_fraction_alu #(.OPERAND_BITS(16)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	frac_req_t pending_ops[$];
	frac_rsp_t expected_results[$];
	int mismatches;
	int checked;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_cycles;
	bit hold_off_req;
	bit hold_off_done;

	// Improper form of one operand: numerator and positive denominator
	function automatic void make_improper(input logic signed [15:0] w, input logic signed [15:0] n,
			input logic signed [15:0] d, output logic [63:0] pn, output logic [63:0] pd);
		logic [63:0] dd;
		logic [63:0] nn;
		dd = 64'(signed'(d));
		if (dd == 0) begin
			dd = 1;
		end
		nn = 64'(signed'(w)) * dd + 64'(signed'(n));
		if (dd[63]) begin
			nn = -nn;
			dd = -dd;
		end
		pn = nn;
		pd = dd;
	endfunction

	// Reduce by the GCD and split into a proper mixed fraction
	function automatic frac_rsp_t reduce_split(input logic [63:0] n, input logic [63:0] d);
		frac_rsp_t r;
		logic [63:0] an;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] t;
		logic [63:0] q;
		logic [63:0] m;
		r = '{res_whole: 0, res_num: 0, res_den: 1, order: ORD_LT, div_error: 1'b0};
		if (d == 0) begin
			d = 1;
		end
		an = n[63] ? -n : n;
		if (an == 0) begin
			return r;
		end
		x = an;
		y = d;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		an = an / x;
		d = d / x;
		q = an / d;
		m = an % d;
		if (n[63]) begin
			q = -q;
			m = -m;
		end
		r.res_whole = q[62:0];
		r.res_num = m[62:0];
		r.res_den = d[61:0];
		return r;
	endfunction

	function automatic frac_rsp_t predict_fraction(input frac_req_t op);
		frac_rsp_t r;
		logic [63:0] n1;
		logic [63:0] d1;
		logic [63:0] n2;
		logic [63:0] d2;
		logic [63:0] num;
		logic [63:0] den;
		r = '{res_whole: 0, res_num: 0, res_den: 1, order: ORD_LT, div_error: 1'b0};
		make_improper(op.a_whole, op.a_num, op.a_den, n1, d1);
		make_improper(op.b_whole, op.b_num, op.b_den, n2, d2);
		case (op.func)
			FN_ADD: r = reduce_split(n1 * d2 + n2 * d1, d1 * d2);
			FN_SUB: r = reduce_split(n1 * d2 - n2 * d1, d1 * d2);
			FN_MUL: r = reduce_split(n1 * n2, d1 * d2);
			FN_DIV: begin
				if (n2 == 0) begin
					r.div_error = 1'b1;
				end else begin
					num = n1 * d2;
					den = d1 * n2;
					if (den[63]) begin
						num = -num;
						den = -den;
					end
					r = reduce_split(num, den);
				end
			end
			FN_CMP: begin
				num = n1 * d2 - n2 * d1;
				if (num == 0) begin
					r.order = ORD_EQ;
				end else if (num[63]) begin
					r.order = ORD_LT;
				end else begin
					r.order = ORD_GT;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Operand value biased toward edges and small numbers
	function automatic logic [15:0] pick_field();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 6)) - 3);
			4, 5: return 16'(int'($urandom_range(0, 40)) - 20);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic frac_req_t random_op();
		frac_req_t op;
		op.func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
			: 3'($urandom_range(0, 4));
		op.a_whole = pick_field();
		op.a_num = pick_field();
		op.a_den = pick_field();
		op.b_whole = pick_field();
		op.b_num = pick_field();
		op.b_den = pick_field();
		return op;
	endfunction

	task automatic add_op(input logic [2:0] f, input int aw, input int an, input int ad,
			input int bw, input int bn, input int bd);
		pending_ops.push_back('{f, 16'(aw), 16'(an), 16'(ad), 16'(bw), 16'(bn), 16'(bd)});
	endtask

	task automatic drain_phase();
		while (pending_ops.size() != 0 || expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Driver: present queued operations, advance on transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			{req.func, req.a_whole, req.a_num, req.a_den, req.b_whole, req.b_num, req.b_den}
				<= '0;
		end else begin
			if (req.valid && req.ready) begin
				expected_results.push_back(predict_fraction(pending_ops.pop_front()));
			end
			if (req.valid && !req.ready) begin
				// hold the offered item
			end else if (pending_ops.size() != 0
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				req.valid <= 1'b1;
				{req.func, req.a_whole, req.a_num, req.a_den, req.b_whole, req.b_num,
					req.b_den} <= pending_ops[0];
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Receiver stall control, with a long hold-off when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold_off_cycles <= 0;
			hold_off_done <= 1'b0;
		end else if (hold_off_req && !hold_off_done) begin
			hold_off_cycles <= 3000;
			hold_off_done <= 1'b1;
			rsp.ready <= 1'b0;
		end else if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Monitor: compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			frac_rsp_t got;
			frac_rsp_t exp_r;
			got = '{rsp.res_whole, rsp.res_num, rsp.res_den, rsp.order, rsp.div_error};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result %p", got);
				end
			end else begin
				exp_r = expected_results.pop_front();
				checked++;
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected %p actual %p", exp_r, got);
					end
				end
			end
		end
	end

	// Run limit
	initial begin
		#300ms;
		$display("== FAIL ==");
		$finish;
	end

	// Stimulus phases
	initial begin
		int phase;
		mismatches = 0;
		checked = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_req = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: every operation, zero and negative denominators, extremes
		add_op(FN_ADD, 1, 1, 2, 2, 1, 3);
		add_op(FN_SUB, 1, 1, 2, 1, 1, 2);
		add_op(FN_SUB, 0, 1, 3, 1, 0, 1);
		add_op(FN_MUL, -2, 1, 3, 3, -1, -4);
		add_op(FN_DIV, 1, 1, 2, 0, 0, 5);
		add_op(FN_DIV, 1, 1, 2, 0, 3, -7);
		add_op(FN_CMP, 1, 1, 2, 1, 2, 4);
		add_op(FN_CMP, 0, 1, 3, 0, 1, 2);
		add_op(FN_CMP, 0, 1, 2, 0, 1, 3);
		add_op(FN_ADD, 3, 5, 0, 1, 1, 0);
		add_op(FN_ADD, -32768, -32768, -32768, -32768, -32768, -32768);
		add_op(FN_MUL, 32767, 32767, 32767, 32767, 32767, 32767);
		add_op(FN_MUL, -32768, 32767, -32768, 32767, -32768, 1);
		add_op(FN_DIV, 32767, -32768, 1, -32768, 32767, -1);
		add_op(FN_SUB, -32768, 32767, -1, 32767, -32768, -1);
		add_op(FN_CMP, -32768, -32768, 1, 32767, 32767, 1);
		add_op(3'd5, 1, 2, 3, 4, 5, 6);
		add_op(3'd6, 0, 0, 0, 0, 0, 0);
		add_op(3'd7, -1, -1, -1, -1, -1, -1);
		add_op(FN_MUL, 0, 0, 0, 5, 1, 2);
		add_op(FN_DIV, 0, 0, 0, 0, 0, 0);
		drain_phase();

		// Random, under each idling pattern
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 88; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 88; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			for (int i = 0; i < 482; i++) begin
				pending_ops.push_back(random_op());
			end
			if (phase == 0) begin
				hold_off_req = 1'b1;
			end
			drain_phase();
		end
		repeat (50) @(posedge clk);

		$display("covered all five operations, unused codes, zero and negative denominators,");
		$display("%0d results checked under four idling patterns and a long hold-off", checked);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
